/* design/mbsh_pkg.sv */
package mbsh_pkg;

    // Internal values are signed Q18.30 held in 48 bits.
    typedef logic signed [47:0] t_z;

    localparam t_z ZMAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [49:0] ZMAX_WIDE = 50'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [49:0] ZMIN_WIDE = -50'sh0_7FFF_FFFF_FFFF;
    localparam t_z BAILOUT = 48'sh0040_0000_0000;
    localparam int LOG2_LN2_Q16 = 34653;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_XY,
        ST_UPD,
        ST_LPREP,
        ST_LSQ,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        CFG_MAX_ITER   = 2'd0,
        CFG_JULIA_MODE = 2'd1,
        CFG_JULIA_RE   = 2'd2,
        CFG_JULIA_IM   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic start;
        t_z   a;
        t_z   b;
    } t_mul_req;

    typedef struct packed {
        logic done;
        t_z   p;
    } t_mul_rsp;

    // Clamp a widened sum to the symmetric 48-bit range.
    function automatic t_z f_sat(input logic signed [49:0] v);
        t_z r;
        if (v > ZMAX_WIDE) begin
            r = ZMAX;
        end else if (v < ZMIN_WIDE) begin
            r = -ZMAX;
        end else begin
            r = v[47:0];
        end
        return r;
    endfunction

endpackage

/* design/mandel_burning_ship_hybrid_unit.sv */
// Channel   Direction  Handshake                   Payload
// input     in         i_in_valid / o_in_ready     i_point_re, i_point_im
// output    out        o_out_valid / i_out_ready   o_smooth_count, o_iterations, o_escaped
// config    in         i_cfg_we (no wait)          i_cfg_index, i_cfg_data
//
// Every multiply runs through one shared 24x24 multiply-accumulate unit and holds the
// sequencer until its product returns. A point first squares its start value; each
// iteration then does a cross product, an update and two squares, and an escape adds
// two 16-bit log2 evaluations (32 squarings on the same unit).
// The reset is synchronous and active low; it restores the register defaults.
// A new transaction is taken only while the sequencer is idle; a finished result waits
// in the output register, so a stalled output delays only the next completion.
module mandel_burning_ship_hybrid_unit #(
    parameter int COORD_WIDTH = 32,
    parameter int COUNT_WIDTH = 16,
    localparam int CfgWidth = (COORD_WIDTH > COUNT_WIDTH) ? COORD_WIDTH : COUNT_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [COORD_WIDTH-1:0] i_point_re,
    input  logic signed [COORD_WIDTH-1:0] i_point_im,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [COUNT_WIDTH+8:0] o_smooth_count,
    output logic [COUNT_WIDTH-1:0]        o_iterations,
    output logic                          o_escaped,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_index,
    input  logic [CfgWidth-1:0]           i_cfg_data
);

    // Coordinates arrive as Q4.(COORD_WIDTH-4) and are moved to Q18.30.
    localparam int ShiftL = (COORD_WIDTH <= 34) ? 34 - COORD_WIDTH : 0;
    localparam int ShiftR = (COORD_WIDTH > 34) ? COORD_WIDTH - 34 : 0;
    localparam int XW     = COUNT_WIDTH + 19;
    localparam int SW     = COUNT_WIDTH + 9;

    function automatic mbsh_pkg::t_z f_to_int(input logic signed [COORD_WIDTH-1:0] v);
        logic [COORD_WIDTH-1:0] mag;
        logic [47:0]            m48;
        mag = v[COORD_WIDTH-1] ? COORD_WIDTH'(-v) : v;
        m48 = 48'(mag >> ShiftR) << ShiftL;
        return v[COORD_WIDTH-1] ? -$signed(m48) : $signed(m48);
    endfunction

    // Configuration registers.
    logic [COUNT_WIDTH-1:0]        r_max_iter;
    logic                          r_julia_mode;
    logic signed [COORD_WIDTH-1:0] r_julia_re;
    logic signed [COORD_WIDTH-1:0] r_julia_im;

    mbsh_pkg::t_state r_state;
    mbsh_pkg::t_state n_state;
    logic             r_kick;
    logic             n_kick;

    mbsh_pkg::t_z r_zr, r_zi, r_cr, r_ci, r_x2, r_y2, r_xy;
    logic [COUNT_WIDTH-1:0] r_iter;
    logic [COUNT_WIDTH-1:0] r_lim;
    logic                   r_first;

    // Logarithm state: argument, integer part, mantissa, fraction bits, step, pass.
    logic [47:0] r_lv;
    logic [4:0]  r_lint;
    logic [32:0] r_y;
    logic [15:0] r_frac;
    logic [3:0]  r_k;
    logic        r_pass;

    // Finished result and output register.
    logic [SW-1:0]          r_res_smooth;
    logic [COUNT_WIDTH-1:0] r_res_iters;
    logic                   r_res_esc;
    logic                   r_out_valid;
    logic [SW-1:0]          r_out_smooth;
    logic [COUNT_WIDTH-1:0] r_out_iters;
    logic                   r_out_esc;

    mbsh_pkg::t_mul_req w_req;
    mbsh_pkg::t_mul_rsp w_rsp;

    logic              w_accept;
    logic              w_load_out;
    logic [48:0]       w_m_raw;
    mbsh_pkg::t_z      w_m;
    logic              w_esc;
    logic              w_last;
    mbsh_pkg::t_z      w_xy_eff;
    mbsh_pkg::t_z      w_zr_next;
    mbsh_pkg::t_z      w_xy2;
    mbsh_pkg::t_z      w_zi_next;
    logic [5:0]        w_lpos;
    logic [32:0]       w_y0;
    logic [4:0]        w_lint0;
    logic [32:0]       w_ysq;
    logic [32:0]       w_y_next;
    logic [15:0]       w_frac_next;
    logic [20:0]       w_lval;
    logic [XW-1:0]     w_ipl;
    logic [XW-1:0]     w_x;
    logic signed [XW-1:0] w_xs;

    mbsh_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign o_in_ready = (r_state == mbsh_pkg::ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_load_out = (r_state == mbsh_pkg::ST_DONE) && (!r_out_valid || i_out_ready);

    // Escape test on |z|^2 = x2 + y2, where y2 is the product just finished.
    assign w_m_raw = 49'(r_x2) + 49'(w_rsp.p);
    assign w_m     = (w_m_raw > 49'(mbsh_pkg::ZMAX)) ? mbsh_pkg::ZMAX : w_m_raw[47:0];
    assign w_esc   = w_m > mbsh_pkg::BAILOUT;
    assign w_last  = (r_iter + COUNT_WIDTH'(1)) == r_lim;

    // Odd iterations fold the cross product to its magnitude (Burning Ship step).
    assign w_xy_eff  = (r_iter[0] && r_xy[47]) ? -r_xy : r_xy;
    assign w_zr_next = mbsh_pkg::f_sat(50'(r_x2) - 50'(r_y2) + 50'(r_cr));
    assign w_xy2     = mbsh_pkg::f_sat(50'(w_xy_eff) <<< 1);
    assign w_zi_next = mbsh_pkg::f_sat(50'(w_xy2) + 50'(r_ci));

    // Leading one of the log argument. On the first pass the argument is |z|^2 above
    // the bailout, so the top bit lies in 38..46; on the second it is log2|z|^2 in Q.16,
    // which lies between 8 and 17, so the top bit is 19 or 20.
    always_comb begin
        if (!r_pass) begin
            w_lpos = 6'd38;
            for (int b = 39; b <= 46; b++) begin
                if (r_lv[b]) begin
                    w_lpos = 6'(b);
                end
            end
            w_y0    = 33'(r_lv >> (w_lpos - 6'd31));
            w_lint0 = 5'(w_lpos - 6'd30);
        end else begin
            w_lpos  = r_lv[20] ? 6'd20 : 6'd19;
            w_y0    = 33'(r_lv << (6'd31 - w_lpos));
            w_lint0 = 5'(w_lpos - 6'd16);
        end
    end

    // One fraction bit per squaring of the Q1.31 mantissa.
    assign w_ysq       = w_rsp.p[33:1];
    assign w_y_next    = w_ysq[32] ? {1'b0, w_ysq[32:1]} : w_ysq;
    assign w_frac_next = {r_frac[14:0], w_ysq[32]};
    assign w_lval      = {r_lint, w_frac_next};

    // Smooth count (i+2) - log2(ln 2) - LL in Q.16, rounded half up to Q.8.
    assign w_ipl = XW'(r_iter) + XW'(2);
    assign w_x   = (w_ipl << 16) + XW'(mbsh_pkg::LOG2_LN2_Q16 + 128) - XW'(w_lval);
    assign w_xs  = $signed(w_x) >>> 8;

    always_comb begin
        unique case (r_state)
            mbsh_pkg::ST_SQX: begin
                w_req.a = r_zr;
                w_req.b = r_zr;
            end
            mbsh_pkg::ST_SQY: begin
                w_req.a = r_zi;
                w_req.b = r_zi;
            end
            mbsh_pkg::ST_XY: begin
                w_req.a = r_zr;
                w_req.b = r_zi;
            end
            default: begin
                w_req.a = 48'(r_y);
                w_req.b = 48'(r_y);
            end
        endcase
        w_req.start = r_kick;
    end

    always_comb begin
        n_state = r_state;
        n_kick  = 1'b0;
        unique case (r_state)
            mbsh_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (r_max_iter == '0) begin
                        n_state = mbsh_pkg::ST_DONE;
                    end else begin
                        n_state = mbsh_pkg::ST_SQX;
                        n_kick  = 1'b1;
                    end
                end
            end
            mbsh_pkg::ST_SQX: begin
                if (w_rsp.done) begin
                    n_state = mbsh_pkg::ST_SQY;
                    n_kick  = 1'b1;
                end
            end
            mbsh_pkg::ST_SQY: begin
                if (w_rsp.done) begin
                    if (r_first) begin
                        n_state = mbsh_pkg::ST_XY;
                        n_kick  = 1'b1;
                    end else if (w_esc) begin
                        n_state = mbsh_pkg::ST_LPREP;
                    end else if (w_last) begin
                        n_state = mbsh_pkg::ST_DONE;
                    end else begin
                        n_state = mbsh_pkg::ST_XY;
                        n_kick  = 1'b1;
                    end
                end
            end
            mbsh_pkg::ST_XY: begin
                if (w_rsp.done) begin
                    n_state = mbsh_pkg::ST_UPD;
                end
            end
            mbsh_pkg::ST_UPD: begin
                n_state = mbsh_pkg::ST_SQX;
                n_kick  = 1'b1;
            end
            mbsh_pkg::ST_LPREP: begin
                n_state = mbsh_pkg::ST_LSQ;
                n_kick  = 1'b1;
            end
            mbsh_pkg::ST_LSQ: begin
                if (w_rsp.done) begin
                    if (r_k != 4'd15) begin
                        n_kick = 1'b1;
                    end else if (!r_pass) begin
                        n_state = mbsh_pkg::ST_LPREP;
                    end else begin
                        n_state = mbsh_pkg::ST_DONE;
                    end
                end
            end
            mbsh_pkg::ST_DONE: begin
                if (w_load_out) begin
                    n_state = mbsh_pkg::ST_IDLE;
                end
            end
            default: n_state = mbsh_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mbsh_pkg::ST_IDLE;
            r_kick  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_kick  <= n_kick;
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter   <= COUNT_WIDTH'(256);
            r_julia_mode <= 1'b0;
            r_julia_re   <= '0;
            r_julia_im   <= '0;
        end else if (i_cfg_we) begin
            unique case (mbsh_pkg::t_cfg_idx'(i_cfg_index))
                mbsh_pkg::CFG_MAX_ITER:   r_max_iter   <= i_cfg_data[COUNT_WIDTH-1:0];
                mbsh_pkg::CFG_JULIA_MODE: r_julia_mode <= i_cfg_data[0];
                mbsh_pkg::CFG_JULIA_RE:   r_julia_re   <= i_cfg_data[COORD_WIDTH-1:0];
                mbsh_pkg::CFG_JULIA_IM:   r_julia_im   <= i_cfg_data[COORD_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            mbsh_pkg::ST_IDLE: begin
                if (w_accept) begin
                    r_iter  <= '0;
                    r_lim   <= r_max_iter;
                    r_first <= 1'b1;
                    r_pass  <= 1'b0;
                    if (r_julia_mode) begin
                        r_zr <= f_to_int(i_point_re);
                        r_zi <= f_to_int(i_point_im);
                        r_cr <= f_to_int(r_julia_re);
                        r_ci <= f_to_int(r_julia_im);
                    end else begin
                        r_zr <= '0;
                        r_zi <= '0;
                        r_cr <= f_to_int(i_point_re);
                        r_ci <= f_to_int(i_point_im);
                    end
                    // A zero limit reports nothing done and no escape.
                    r_res_smooth <= '0;
                    r_res_iters  <= '0;
                    r_res_esc    <= 1'b0;
                end
            end
            mbsh_pkg::ST_SQX: begin
                if (w_rsp.done) begin
                    r_x2 <= w_rsp.p;
                end
            end
            mbsh_pkg::ST_SQY: begin
                if (w_rsp.done) begin
                    r_y2 <= w_rsp.p;
                    if (r_first) begin
                        r_first <= 1'b0;
                    end else if (w_esc) begin
                        r_lv <= w_m;
                    end else if (w_last) begin
                        r_res_smooth <= SW'(r_lim) << 8;
                        r_res_iters  <= r_lim;
                        r_res_esc    <= 1'b0;
                    end else begin
                        r_iter <= r_iter + COUNT_WIDTH'(1);
                    end
                end
            end
            mbsh_pkg::ST_XY: begin
                if (w_rsp.done) begin
                    r_xy <= w_rsp.p;
                end
            end
            mbsh_pkg::ST_UPD: begin
                r_zr <= w_zr_next;
                r_zi <= w_zi_next;
            end
            mbsh_pkg::ST_LPREP: begin
                r_y    <= w_y0;
                r_lint <= w_lint0;
                r_frac <= '0;
                r_k    <= '0;
            end
            mbsh_pkg::ST_LSQ: begin
                if (w_rsp.done) begin
                    r_y    <= w_y_next;
                    r_frac <= w_frac_next;
                    r_k    <= r_k + 4'd1;
                    if (r_k == 4'd15) begin
                        if (!r_pass) begin
                            r_lv   <= 48'(w_lval);
                            r_pass <= 1'b1;
                        end else begin
                            r_res_smooth <= w_xs[SW-1:0];
                            r_res_iters  <= r_iter + COUNT_WIDTH'(1);
                            r_res_esc    <= 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    // Output register: filled when a point completes, emptied by the consumer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_smooth <= r_res_smooth;
            r_out_iters  <= r_res_iters;
            r_out_esc    <= r_res_esc;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_smooth_count = $signed(r_out_smooth);
    assign o_iterations   = r_out_iters;
    assign o_escaped      = r_out_esc;

    // A product only comes back while the sequencer waits on the multiplier.
    a_mul_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == mbsh_pkg::ST_SQX || r_state == mbsh_pkg::ST_SQY ||
                        r_state == mbsh_pkg::ST_XY || r_state == mbsh_pkg::ST_LSQ))
        else $error("multiplier result outside a wait state");

    // A point that stayed bounded reports its limit scaled to Q.8.
    a_inside_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_escaped) |->
            (r_out_smooth == (SW'(o_iterations) << 8)))
        else $error("bounded point with inconsistent smooth count");

    // An escape always follows at least one iteration.
    a_escape_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_escaped) |-> (o_iterations != '0))
        else $error("escape reported with zero iterations");

endmodule

/* design/mbsh_mul.sv */
module mbsh_mul (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mbsh_pkg::t_mul_req  i_req,
    output mbsh_pkg::t_mul_rsp  o_rsp
);

    logic         r_busy;
    logic [2:0]   r_cnt;
    logic [46:0]  r_ma;
    logic [46:0]  r_mb;
    logic         r_neg;
    logic [47:0]  r_pp;
    logic [1:0]   r_pidx;
    logic [93:0]  r_acc;
    logic         r_done;
    mbsh_pkg::t_z r_p;

    logic [46:0]  w_abs_a;
    logic [46:0]  w_abs_b;
    logic [23:0]  w_op_a;
    logic [23:0]  w_op_b;
    logic [47:0]  w_prod;
    logic [93:0]  w_pp_ext;
    logic [63:0]  w_q;
    mbsh_pkg::t_z w_mag;
    mbsh_pkg::t_z w_res;
    mbsh_pkg::t_z w_neg_a;
    mbsh_pkg::t_z w_neg_b;

    assign w_neg_a = -i_req.a;
    assign w_neg_b = -i_req.b;
    assign w_abs_a = i_req.a[47] ? w_neg_a[46:0] : i_req.a[46:0];
    assign w_abs_b = i_req.b[47] ? w_neg_b[46:0] : i_req.b[46:0];

    // Partial product order: lo*lo, lo*hi, hi*lo, hi*hi.
    assign w_op_a = r_cnt[1] ? {1'b0, r_ma[46:24]} : r_ma[23:0];
    assign w_op_b = r_cnt[0] ? {1'b0, r_mb[46:24]} : r_mb[23:0];
    assign w_prod = 48'(w_op_a) * 48'(w_op_b);

    always_comb begin
        case (r_pidx)
            2'd0:    w_pp_ext = 94'(r_pp);
            2'd3:    w_pp_ext = 94'(r_pp) << 48;
            default: w_pp_ext = 94'(r_pp) << 24;
        endcase
    end

    assign w_q   = r_acc[93:30];
    assign w_mag = (w_q > 64'(mbsh_pkg::ZMAX)) ? mbsh_pkg::ZMAX : w_q[47:0];
    assign w_res = r_neg ? -w_mag : w_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == 3'd5) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_ma  <= w_abs_a;
            r_mb  <= w_abs_b;
            r_neg <= i_req.a[47] ^ i_req.b[47];
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_cnt <= 3'd3) begin
                r_pp   <= w_prod;
                r_pidx <= r_cnt[1:0];
            end
            if (r_cnt >= 3'd1 && r_cnt <= 3'd4) begin
                r_acc <= r_acc + w_pp_ext;
            end
            if (r_cnt == 3'd5) begin
                r_p <= w_res;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.p    = r_p;

endmodule
